// ----- sv/dll_pkg.sv -----
// Shared constants, types and helpers for the doubly linked list engine.
package dll_pkg;

    localparam int NODES      = 64;
    localparam int VALUE_BITS = 32;
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = $clog2(NODES);
    localparam int PTR_W      = $clog2(NODES + 1);
    localparam int VAL_W      = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam ptr_t NIL = ptr_t'(NODES);

    localparam func_t FN_ADD_FRONT = func_t'(0);
    localparam func_t FN_ADD_BACK  = func_t'(1);
    localparam func_t FN_DELETE    = func_t'(2);

    localparam stat_t ST_DONE = stat_t'(0);
    localparam stat_t ST_FULL = stat_t'(1);
    localparam stat_t ST_MISS = stat_t'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WR,
        S_ADD_LINK,
        S_DEL_CMP,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_FIN
    } state_t;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        stat_t status;
        len_t  length;
    } out_item_t;

    function automatic logic ptr_ok(input ptr_t p);
        return p < NIL;
    endfunction

endpackage

// ----- sv/dll_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/doubly_linked_list_engine_top.sv -----
// Top level of the doubly linked list engine: sequencer, pointers and link memories.
//
// Usage: each item on the req channel (valid/ready) carries func and value.
// func selects add at front, add at back, or delete of the first node from
// the front holding value; code 3 changes nothing. Each item yields exactly one
// item on the rsp channel with status (done, full, not found) and the list
// length after the operation.
// Values and links live in three RAMs with registered reads; the sequencer
// reads, updates and writes them back through one read and one write port per RAM.
// An add passes through S_ADD_WR, S_ADD_LINK and S_FIN; a delete spends one
// S_DEL_CMP step per node visited from the front, then S_DEL_UNLINK, S_DEL_FREE
// and S_FIN on a hit, or goes to S_FIN on a miss. An add to a full pool, a
// delete on an empty list and code 3 go straight from idle to S_FIN.
// The delete search visits one node per cycle through the link RAM, up to NODES nodes.
// req_ready is high only while the sequencer is idle. A finished result sits in
// an output register, so a new item is taken while the previous result is
// still waiting; if the receiver stalls, the next result waits at the end of
// its operation until the register frees up.
// Reset: list empty, all nodes on the free list; no clearing pass is needed.
module doubly_linked_list_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dll_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dll_pkg::out_item_t rsp
);

    dll_pkg::state_t    state_reg, state_next;
    dll_pkg::func_t     func_reg, func_next;
    dll_pkg::val_t      val_reg, val_next;
    dll_pkg::ptr_t      node_reg, node_next;
    dll_pkg::ptr_t      nx_reg, nx_next;
    dll_pkg::ptr_t      pv_reg, pv_next;
    dll_pkg::idx_t      steps_reg, steps_next;
    dll_pkg::stat_t     st_reg, st_next;
    dll_pkg::ptr_t      head_reg, head_next;
    dll_pkg::ptr_t      tail_reg, tail_next;
    dll_pkg::ptr_t      free_reg, free_next;
    dll_pkg::ptr_t      count_reg, count_next;
    dll_pkg::out_item_t rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [dll_pkg::NODES-1:0] nxt_vld_reg;
    logic [dll_pkg::NODES-1:0] prv_vld_reg;
    dll_pkg::idx_t             rd_addr_reg;
    logic                      nxt_rvld_reg;
    logic                      prv_rvld_reg;

    logic          accept;
    logic          match;
    dll_pkg::idx_t rd_addr;
    dll_pkg::ptr_t nxt_q;
    dll_pkg::ptr_t prv_q;

    logic          val_we;
    dll_pkg::idx_t val_waddr;
    dll_pkg::val_t val_wdata;
    dll_pkg::val_t val_rdata;
    logic          nxt_we;
    dll_pkg::idx_t nxt_waddr;
    dll_pkg::ptr_t nxt_wdata;
    dll_pkg::ptr_t nxt_rdata;
    logic          prv_we;
    dll_pkg::idx_t prv_waddr;
    dll_pkg::ptr_t prv_wdata;
    dll_pkg::ptr_t prv_rdata;

    dll_ram #(.WIDTH(dll_pkg::VAL_W), .DEPTH(dll_pkg::NODES)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    dll_ram #(.WIDTH(dll_pkg::PTR_W), .DEPTH(dll_pkg::NODES)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    dll_ram #(.WIDTH(dll_pkg::PTR_W), .DEPTH(dll_pkg::NODES)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    assign req_ready = (state_reg == dll_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // unwritten link entries read as their reset values
    assign nxt_q = nxt_rvld_reg ? nxt_rdata
                                : dll_pkg::ptr_t'(rd_addr_reg) + dll_pkg::ptr_t'(1);
    assign prv_q = prv_rvld_reg ? prv_rdata : dll_pkg::NIL;
    assign match = (val_rdata == val_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dll_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((req.func == dll_pkg::FN_ADD_FRONT || req.func == dll_pkg::FN_ADD_BACK)
                        && dll_pkg::ptr_ok(free_reg))
                    begin
                        state_next = dll_pkg::S_ADD_WR;
                    end
                    else if (req.func == dll_pkg::FN_DELETE && dll_pkg::ptr_ok(head_reg))
                    begin
                        state_next = dll_pkg::S_DEL_CMP;
                    end
                    else
                    begin
                        state_next = dll_pkg::S_FIN;
                    end
                end
            end
            dll_pkg::S_ADD_WR:
            begin
                state_next = dll_pkg::S_ADD_LINK;
            end
            dll_pkg::S_ADD_LINK:
            begin
                state_next = dll_pkg::S_FIN;
            end
            dll_pkg::S_DEL_CMP:
            begin
                if (match)
                begin
                    state_next = dll_pkg::S_DEL_UNLINK;
                end
                else if (!dll_pkg::ptr_ok(nxt_q)
                         || steps_reg == dll_pkg::idx_t'(dll_pkg::NODES - 1))
                begin
                    state_next = dll_pkg::S_FIN;
                end
            end
            dll_pkg::S_DEL_UNLINK:
            begin
                state_next = dll_pkg::S_DEL_FREE;
            end
            dll_pkg::S_DEL_FREE:
            begin
                state_next = dll_pkg::S_FIN;
            end
            dll_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = dll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dll_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next      = func_reg;
        val_next       = val_reg;
        node_next      = node_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        steps_next     = steps_reg;
        st_next        = st_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rd_addr        = '0;
        val_we         = 1'b0;
        val_waddr      = node_reg[dll_pkg::IDX_W-1:0];
        val_wdata      = val_reg;
        nxt_we         = 1'b0;
        nxt_waddr      = node_reg[dll_pkg::IDX_W-1:0];
        nxt_wdata      = dll_pkg::NIL;
        prv_we         = 1'b0;
        prv_waddr      = node_reg[dll_pkg::IDX_W-1:0];
        prv_wdata      = dll_pkg::NIL;

        unique case (state_reg)
            dll_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = req.func;
                    val_next   = dll_pkg::val_t'(req.value);
                    steps_next = '0;
                    st_next    = dll_pkg::ST_DONE;
                    case (req.func) inside
                        dll_pkg::FN_ADD_FRONT, dll_pkg::FN_ADD_BACK:
                        begin
                            node_next = free_reg;
                            rd_addr   = free_reg[dll_pkg::IDX_W-1:0];
                            if (!dll_pkg::ptr_ok(free_reg))
                            begin
                                st_next = dll_pkg::ST_FULL;
                            end
                        end
                        dll_pkg::FN_DELETE:
                        begin
                            node_next = head_reg;
                            rd_addr   = head_reg[dll_pkg::IDX_W-1:0];
                            if (!dll_pkg::ptr_ok(head_reg))
                            begin
                                st_next = dll_pkg::ST_MISS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dll_pkg::S_ADD_WR:
            begin
                free_next = nxt_q;
                val_we    = 1'b1;
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                if (func_reg == dll_pkg::FN_ADD_FRONT && dll_pkg::ptr_ok(head_reg))
                begin
                    nxt_wdata = head_reg;
                end
                if (func_reg == dll_pkg::FN_ADD_BACK && dll_pkg::ptr_ok(tail_reg))
                begin
                    prv_wdata = tail_reg;
                end
            end
            dll_pkg::S_ADD_LINK:
            begin
                count_next = count_reg + dll_pkg::ptr_t'(1);
                if (func_reg == dll_pkg::FN_ADD_FRONT)
                begin
                    if (!dll_pkg::ptr_ok(head_reg))
                    begin
                        tail_next = node_reg;
                    end
                    else
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = head_reg[dll_pkg::IDX_W-1:0];
                        prv_wdata = node_reg;
                    end
                    head_next = node_reg;
                end
                else
                begin
                    if (!dll_pkg::ptr_ok(tail_reg))
                    begin
                        head_next = node_reg;
                    end
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = tail_reg[dll_pkg::IDX_W-1:0];
                        nxt_wdata = node_reg;
                    end
                    tail_next = node_reg;
                end
            end
            dll_pkg::S_DEL_CMP:
            begin
                if (match)
                begin
                    nx_next = nxt_q;
                    pv_next = prv_q;
                end
                else if (!dll_pkg::ptr_ok(nxt_q)
                         || steps_reg == dll_pkg::idx_t'(dll_pkg::NODES - 1))
                begin
                    st_next = dll_pkg::ST_MISS;
                end
                else
                begin
                    node_next  = nxt_q;
                    steps_next = steps_reg + dll_pkg::idx_t'(1);
                    rd_addr    = nxt_q[dll_pkg::IDX_W-1:0];
                end
            end
            dll_pkg::S_DEL_UNLINK:
            begin
                if (dll_pkg::ptr_ok(pv_reg))
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = pv_reg[dll_pkg::IDX_W-1:0];
                    nxt_wdata = nx_reg;
                end
                else
                begin
                    head_next = nx_reg;
                end
                if (dll_pkg::ptr_ok(nx_reg))
                begin
                    prv_we    = 1'b1;
                    prv_waddr = nx_reg[dll_pkg::IDX_W-1:0];
                    prv_wdata = pv_reg;
                end
                else
                begin
                    tail_next = pv_reg;
                end
            end
            dll_pkg::S_DEL_FREE:
            begin
                nxt_we    = 1'b1;
                nxt_wdata = free_reg;
                prv_we    = 1'b1;
                free_next = node_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - dll_pkg::ptr_t'(1);
                end
            end
            dll_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status = st_reg;
                    rsp_next.length = dll_pkg::len_t'(count_reg);
                    rsp_valid_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dll_pkg::S_IDLE;
            head_reg      <= dll_pkg::NIL;
            tail_reg      <= dll_pkg::NIL;
            free_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            nxt_vld_reg   <= '0;
            prv_vld_reg   <= '0;
            nxt_rvld_reg  <= 1'b0;
            prv_rvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            nxt_rvld_reg  <= nxt_vld_reg[rd_addr];
            prv_rvld_reg  <= prv_vld_reg[rd_addr];
            if (nxt_we)
            begin
                nxt_vld_reg[nxt_waddr] <= 1'b1;
            end
            if (prv_we)
            begin
                prv_vld_reg[prv_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        val_reg     <= val_next;
        node_reg    <= node_next;
        nx_reg      <= nx_next;
        pv_reg      <= pv_next;
        steps_reg   <= steps_next;
        st_reg      <= st_next;
        rsp_reg     <= rsp_next;
        rd_addr_reg <= rd_addr;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dll_pkg::NIL)
        else $error("node count above pool size");

    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dll_pkg::S_IDLE |->
            dll_pkg::ptr_ok(head_reg) == dll_pkg::ptr_ok(tail_reg))
        else $error("head and tail disagree on empty list");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dll_pkg::S_IDLE |->
            dll_pkg::ptr_ok(head_reg) == (count_reg != '0))
        else $error("head pointer inconsistent with count");

    a_free_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dll_pkg::S_IDLE |->
            dll_pkg::ptr_ok(free_reg) == (count_reg != dll_pkg::NIL))
        else $error("free list inconsistent with count");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dll_pkg::S_FIN && rsp_valid_reg && !rsp_ready)
            |=> (state_reg == dll_pkg::S_FIN && $stable(rsp_reg)))
        else $error("result overwritten while receiver stalls");

endmodule
